>>> rtl/core/ncsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncsa_pkg
// Shared types and constants of the nearest-centroid slot associator.
// ----------------------------------------------------------------------------
package ncsa_pkg;

    localparam int unsigned COORD_FIELD_W = 16;
    localparam int unsigned SLOT_IDX_W    = 5;
    localparam int unsigned AGE_W         = 8;
    localparam int unsigned GATE_W        = 15;
    localparam int unsigned GATE_SQ_W     = 2 * GATE_W;
    localparam int unsigned CFG_IDX_W     = 4;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GATE_DISTANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT     = CFG_IDX_W'(1);

    localparam logic [GATE_W-1:0] GATE_DISTANCE_RST = GATE_W'(500);
    localparam logic [AGE_W-1:0]  AGE_LIMIT_RST     = AGE_W'(100);
    localparam logic [AGE_W-1:0]  AGE_MAX           = AGE_W'(255);

    // best squared distance starts at 1000 mm squared
    localparam int unsigned INIT_BEST_MM = 1000;
    localparam int unsigned INIT_BEST_SQ = INIT_BEST_MM * INIT_BEST_MM;

    typedef enum logic [1:0] {
        OUTCOME_CLAIMED    = 2'd0,
        OUTCOME_MATCHED    = 2'd1,
        OUTCOME_UNASSIGNED = 2'd2
    } t_outcome;

    typedef struct packed {
        logic signed [COORD_FIELD_W-1:0] centroid_x;
        logic signed [COORD_FIELD_W-1:0] centroid_y;
        logic signed [COORD_FIELD_W-1:0] centroid_z;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_index;
        t_outcome              outcome;
    } t_out_item;

    // per-slot bookkeeping word
    typedef struct packed {
        logic             valid;
        logic [AGE_W-1:0] age;
    } t_meta;

    // write request into the slot memories
    typedef struct packed {
        logic  meta_we;
        logic  center_we;
        t_meta meta;
    } t_slot_wr;

endpackage
`default_nettype wire

>>> rtl/core/ncsa_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncsa_slot_mem
// Slot center memory and slot meta memory, one read and one write port each.
// ----------------------------------------------------------------------------
module ncsa_slot_mem #(
    parameter int unsigned SLOTS       = 8,
    parameter int unsigned COORD_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(SLOTS)-1:0]     i_rd_addr,
    output      ncsa_pkg::t_meta              o_rd_meta,
    output      logic [3*COORD_WIDTH-1:0]     o_rd_center,
    input  wire ncsa_pkg::t_slot_wr           i_wr,
    input  wire logic [$clog2(SLOTS)-1:0]     i_wr_addr,
    input  wire logic [3*COORD_WIDTH-1:0]     i_wr_center
);

    localparam int unsigned CTR_W = 3 * COORD_WIDTH;

    logic [CTR_W-1:0]      r_center_mem [SLOTS];
    ncsa_pkg::t_meta       r_meta_mem   [SLOTS];
    logic [SLOTS-1:0]      r_init;        // meta entry written since reset
    logic [CTR_W-1:0]      r_rd_center;
    ncsa_pkg::t_meta       r_rd_meta_raw;
    logic                  r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_wr.center_we) begin
            r_center_mem[i_wr_addr] <= i_wr_center;
        end
        if (i_wr.meta_we) begin
            r_meta_mem[i_wr_addr] <= i_wr.meta;
        end
        if (i_rd_en) begin
            r_rd_center   <= r_center_mem[i_rd_addr];
            r_rd_meta_raw <= r_meta_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr.meta_we) begin
                r_init[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_init <= r_init[i_rd_addr];
            end
        end
    end

    // unwritten entry reads as free, age zero
    assign o_rd_meta   = r_rd_init ? r_rd_meta_raw : '0;
    assign o_rd_center = r_rd_center;

endmodule
`default_nettype wire

>>> rtl/core/ncsa_dist_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncsa_dist_unit
// Two-stage squared Euclidean distance: squares registered, then summed.
// ----------------------------------------------------------------------------
module ncsa_dist_unit #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic [3*COORD_WIDTH-1:0]     i_centroid,
    input  wire logic [3*COORD_WIDTH-1:0]     i_center,
    output      logic [2*COORD_WIDTH+3:0]     o_dist_sq
);

    localparam int unsigned CW    = COORD_WIDTH;
    localparam int unsigned SQ_W  = 2 * CW + 2;
    localparam int unsigned SUM_W = 2 * CW + 4;

    logic signed [CW:0]     diff [3];
    logic signed [SQ_W-1:0] prod [3];
    logic [SQ_W-1:0]        r_sq [3];
    logic [SUM_W-1:0]       r_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = $signed({i_centroid[k*CW+CW-1], i_centroid[k*CW +: CW]})
                    - $signed({i_center[k*CW+CW-1], i_center[k*CW +: CW]});
            prod[k] = diff[k] * diff[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sq[k] <= SQ_W'(prod[k]);
        end
        r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    assign o_dist_sq = r_sum;

endmodule
`default_nettype wire

>>> rtl/core/nearest_centroid_slot_associator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_centroid_slot_associator
// Assigns each cluster centroid to the nearest tracked slot or a free slot.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data) carries one centroid
//    (x, y, z in mm). A transfer happens when valid is high and stall is low.
//  - Output channel (o_out_valid / i_out_stall / o_out_data) returns one
//    result per centroid: slot index and outcome (claimed, matched, none).
//  - Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//    index 0 is the gate distance, index 1 the age limit. Other indexes are
//    dropped. Write only while the block is idle.
//  - One item at a time. Slots are read one per cycle from the meta and
//    center memories; each read goes through the read/distance pipe
//    (p1 mem data, p2 squares, p3 sum); the walk covers every slot but
//    ends early when a free slot is claimed before any match.
//  - The result sits in an output register; a stalled receiver holds it,
//    and the block takes the next centroid meanwhile, waiting at the end of
//    that one only if the old result is still not taken.
//  - Reset clears control state, restores register defaults and marks
//    every slot free with age zero (per-slot init bits, no clearing pass).
// ----------------------------------------------------------------------------
module nearest_centroid_slot_associator #(
    parameter int unsigned SLOTS       = 8,
    parameter int unsigned COORD_WIDTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output      logic                                o_in_stall,
    input  wire ncsa_pkg::t_in_item                  i_in_data,
    output      logic                                o_out_valid,
    input  wire logic                                i_out_stall,
    output      ncsa_pkg::t_out_item                 o_out_data,
    input  wire logic                                i_cfg_valid,
    output      logic                                o_cfg_ready,
    input  wire logic [ncsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ncsa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned CW     = COORD_WIDTH;
    localparam int unsigned IDX_W  = $clog2(SLOTS);
    localparam int unsigned RAW_W  = (CW > ncsa_pkg::COORD_FIELD_W) ?
                                     CW : ncsa_pkg::COORD_FIELD_W;
    localparam int unsigned SUM_W  = 2 * CW + 4;
    localparam int unsigned CMP_W  = (SUM_W > ncsa_pkg::GATE_SQ_W) ?
                                     SUM_W : ncsa_pkg::GATE_SQ_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CMP_W-1:0] BEST_RST = CMP_W'(ncsa_pkg::INIT_BEST_SQ);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ncsa_pkg::GATE_W-1:0]    r_gate_dist;
    logic [ncsa_pkg::AGE_W-1:0]     r_age_limit;
    logic [ncsa_pkg::GATE_SQ_W-1:0] r_gate_sq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_dist <= ncsa_pkg::GATE_DISTANCE_RST;
            r_age_limit <= ncsa_pkg::AGE_LIMIT_RST;
            r_gate_sq   <= ncsa_pkg::GATE_SQ_W'(ncsa_pkg::GATE_DISTANCE_RST)
                         * ncsa_pkg::GATE_SQ_W'(ncsa_pkg::GATE_DISTANCE_RST);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ncsa_pkg::REG_GATE_DISTANCE: begin
                        r_gate_dist <= i_cfg_data[ncsa_pkg::GATE_W-1:0];
                    end
                    ncsa_pkg::REG_AGE_LIMIT: begin
                        r_age_limit <= i_cfg_data[ncsa_pkg::AGE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // gate squared is held ready; the user must change config only while idle, the block does not enforce it
            r_gate_sq <= ncsa_pkg::GATE_SQ_W'(r_gate_dist)
                       * ncsa_pkg::GATE_SQ_W'(r_gate_dist);
        end
    end

    // ------------------------------------------------------------------
    // Input capture: coordinates taken as COORD_WIDTH-bit two's complement
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]     raw_x, raw_y, raw_z;
    logic [3*CW-1:0]      in_coords;
    logic                 in_xfer;

    assign raw_x     = RAW_W'($unsigned(i_in_data.centroid_x));
    assign raw_y     = RAW_W'($unsigned(i_in_data.centroid_y));
    assign raw_z     = RAW_W'($unsigned(i_in_data.centroid_z));
    assign in_coords = {raw_z[CW-1:0], raw_y[CW-1:0], raw_x[CW-1:0]};

    t_state r_state, n_state;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    logic [3*CW-1:0] r_centroid;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_centroid <= in_coords;
        end
    end

    // ------------------------------------------------------------------
    // Walk pipeline: issue -> p1 (mem data) -> p2 (squares) -> p3 (sum)
    // ------------------------------------------------------------------
    logic              r_issue_on;
    logic [IDX_W-1:0]  r_issue_idx;
    logic              r_p1_vld, r_p2_vld, r_p3_vld;
    logic [IDX_W-1:0]  r_p1_idx, r_p2_idx, r_p3_idx;
    ncsa_pkg::t_meta   r_p2_meta, r_p3_meta;

    logic              rd_en;
    ncsa_pkg::t_meta   rd_meta;
    logic [3*CW-1:0]   rd_center;
    ncsa_pkg::t_slot_wr wr_req;
    logic [IDX_W-1:0]  wr_addr;
    logic [SUM_W-1:0]  dist_sq;

    assign rd_en = (r_state == ST_WALK) && r_issue_on;

    ncsa_slot_mem #(
        .SLOTS       (SLOTS),
        .COORD_WIDTH (CW)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_addr   (r_issue_idx),
        .o_rd_meta   (rd_meta),
        .o_rd_center (rd_center),
        .i_wr        (wr_req),
        .i_wr_addr   (wr_addr),
        .i_wr_center (r_centroid)
    );

    ncsa_dist_unit #(
        .COORD_WIDTH (CW)
    ) u_dist (
        .i_clk       (i_clk),
        .i_centroid  (r_centroid),
        .i_center    (rd_center),
        .o_dist_sq   (dist_sq)
    );

    // ------------------------------------------------------------------
    // Slot decision at p3
    // ------------------------------------------------------------------
    logic                   r_found;
    logic [CMP_W-1:0]       r_best, n_best;
    logic [IDX_W-1:0]       r_win, n_win;
    logic                   n_found;
    ncsa_pkg::t_out_item    r_res, n_res;

    logic                   age_freed;
    logic                   slot_live;
    logic [ncsa_pkg::AGE_W-1:0] age_base, age_next;
    logic [CMP_W-1:0]       dist_ext;
    logic                   claim, hit, last;

    always_comb begin
        age_freed = r_p3_meta.age > r_age_limit;
        slot_live = r_p3_meta.valid && !age_freed;
        age_base  = age_freed ? '0 : r_p3_meta.age;
        age_next  = (age_base == ncsa_pkg::AGE_MAX) ? age_base
                                                    : age_base + 1'b1;
        dist_ext  = CMP_W'(dist_sq);
        // free slot before any match takes the centroid and ends the walk
        claim     = (r_state == ST_WALK) && r_p3_vld && !slot_live && !r_found;
        // strict compares: lower index wins a tie
        hit       = (r_state == ST_WALK) && r_p3_vld && slot_live
                 && (dist_ext < CMP_W'(r_gate_sq)) && (dist_ext < r_best);
        last      = r_p3_vld && (r_p3_idx == LAST_IDX);
    end

    // memory writes: per-slot age/valid update during walk, winner at commit
    always_comb begin
        wr_req  = '0;
        wr_addr = r_p3_idx;
        if ((r_state == ST_WALK) && r_p3_vld) begin
            wr_req.meta_we = 1'b1;
            if (claim) begin
                wr_req.center_we  = 1'b1;
                wr_req.meta.valid = 1'b1;
                wr_req.meta.age   = age_base;
            end else begin
                wr_req.meta.valid = slot_live;
                wr_req.meta.age   = age_next;
            end
        end else if ((r_state == ST_COMMIT) && r_found) begin
            wr_addr           = r_win;
            wr_req.meta_we    = 1'b1;
            wr_req.center_we  = 1'b1;
            wr_req.meta.valid = 1'b1;
            wr_req.meta.age   = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_found = r_found;
        n_best  = r_best;
        n_win   = r_win;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_WALK;
                    n_found = 1'b0;
                    n_best  = BEST_RST;
                    n_win   = '0;
                end
            end
            ST_WALK: begin
                if (claim) begin
                    n_res.slot_index = ncsa_pkg::SLOT_IDX_W'(r_p3_idx);
                    n_res.outcome    = ncsa_pkg::OUTCOME_CLAIMED;
                    n_state          = ST_FINISH;
                end else begin
                    if (hit) begin
                        n_found = 1'b1;
                        n_best  = dist_ext;
                        n_win   = r_p3_idx;
                    end
                    if (last) begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                if (r_found) begin
                    n_res.slot_index = ncsa_pkg::SLOT_IDX_W'(r_win);
                    n_res.outcome    = ncsa_pkg::OUTCOME_MATCHED;
                end else begin
                    n_res.slot_index = '0;
                    n_res.outcome    = ncsa_pkg::OUTCOME_UNASSIGNED;
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        r_win  <= n_win;
        r_res  <= n_res;
    end

    // issue counter and pipeline tags; a claim flushes reads in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_on  <= 1'b0;
            r_issue_idx <= '0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_p3_vld    <= 1'b0;
        end else if (claim) begin
            r_issue_on  <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_p3_vld    <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_issue_on  <= 1'b1;
                r_issue_idx <= '0;
            end else if (rd_en) begin
                if (r_issue_idx == LAST_IDX) begin
                    r_issue_on <= 1'b0;
                end else begin
                    r_issue_idx <= r_issue_idx + 1'b1;
                end
            end
            r_p1_vld <= rd_en;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx  <= r_issue_idx;
        r_p2_idx  <= r_p1_idx;
        r_p2_meta <= rd_meta;
        r_p3_idx  <= r_p2_idx;
        r_p3_meta <= r_p2_meta;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                r_out_vld;
    ncsa_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_FINISH) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FINISH) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_best_in_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_found) |-> (r_best < CMP_W'(r_gate_sq)))
        else $error("best candidate outside gate");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p3_vld && r_p3_idx == LAST_IDX)
        |-> (!r_issue_on && !r_p1_vld && !r_p2_vld))
        else $error("reads still in flight after last slot");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_vld && i_out_stall)
        |=> (r_state == ST_FINISH))
        else $error("result left finish while output blocked");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_FINISH))
        else $error("output loaded outside finish");

    a_one_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(claim && hit))
        else $error("claim and match on the same slot");

endmodule
`default_nettype wire
